// ===== src/ave_pkg.sv =====
// Package for the address view extractor: character codes, view codes and the
// command/status structs that join the controller and the datapath.
// No dependencies.
`default_nettype none

package ave_pkg;

    // Address text characters the scan looks for
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // View select codes
    typedef enum logic [1:0] {
        VIEW_WHOLE    = 2'd0,
        VIEW_NODE_ID  = 2'd1,
        VIEW_NO_HOST  = 2'd2,
        VIEW_NODE_SPC = 2'd3
    } t_view;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // store and scan the accepted input byte
        logic setup;  // latch view bounds for the finished address
        logic rd;     // read the store at the current position
        logic adv;    // step to the next position of the view
        logic clr;    // clear per-address state
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic view_empty;  // valid during setup: the chosen view has no bytes
        logic out_last;    // current output transaction closes the address
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/ave_if.sv =====
// Valid/ready channel interfaces for address bytes in and view bytes out.
// No dependencies.
`default_nettype none

interface ave_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] addr_byte;
    logic       last_byte;

    modport source (output valid, output addr_byte, output last_byte, input ready);
    modport sink   (input valid, input addr_byte, input last_byte, output ready);
endinterface

interface ave_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       field_empty;
    logic       too_long;

    modport source (output valid, output out_byte, output out_last,
                    output field_empty, output too_long, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input field_empty, input too_long, output ready);
endinterface

`default_nettype wire

// ===== src/ave_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ave_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, and read port that holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ave_datapath.sv =====
// Datapath: address byte store, node-id scan, slash trackers, view bounds and
// the emit position. Depends on ave_pkg and ave_ram.
`default_nettype none

module ave_datapath #(
    parameter int MAX_LEN = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ave_pkg::t_ctl_cmd  i_cmd,
    output ave_pkg::t_dp_status     o_sts,
    input  wire logic [7:0]         i_addr_byte,
    input  wire ave_pkg::t_view     i_view_sel,
    output logic      [7:0]         o_out_byte,
    output logic                    o_out_last,
    output logic                    o_field_empty,
    output logic                    o_too_long
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam logic [CW-1:0] LenC = CW'(MAX_LEN);
    localparam logic [CW-1:0] OneC = CW'(1);

    typedef enum logic [2:0] {
        SC_START,
        SC_SLASH_LEFT,
        SC_SKIP,
        SC_SCAN,
        SC_COLON,
        SC_COLON_SLASH,
        SC_AT_NODE
    } t_scan;

    t_scan          r_scan, n_scan;
    logic [CW-1:0]  r_count;
    logic           r_found;
    logic [CW-1:0]  r_node;
    logic           r_ovf;
    logic           r_s0_vld, r_s1_vld;      // first slash at >= s, at >= s+1
    logic [CW-1:0]  r_s0_pos, r_s1_pos;
    logic [CW-1:0]  r_cur, r_hi;
    logic           r_empty;

    logic           slash, found_now, store_ok;
    logic [CW-1:0]  s_eff, n_lo, n_hi;
    logic [7:0]     ram_rdata;

    // Scan step for the incoming byte
    always_comb begin
        slash     = (i_addr_byte == ave_pkg::CH_SLASH);
        found_now = 1'b0;
        n_scan    = r_scan;
        case (r_scan)
            SC_START:       n_scan = slash ? SC_SLASH_LEFT : SC_SCAN;
            SC_SLASH_LEFT: begin
                if (slash) begin
                    n_scan = SC_SKIP;
                end else begin
                    n_scan    = SC_AT_NODE;
                    found_now = 1'b1;
                end
            end
            SC_SKIP: begin
                if (slash) begin
                    n_scan    = SC_AT_NODE;
                    found_now = 1'b1;
                end
            end
            SC_SCAN: begin
                if (i_addr_byte == ave_pkg::CH_COLON) begin
                    n_scan = SC_COLON;
                end
            end
            SC_COLON:       n_scan = slash ? SC_COLON_SLASH : SC_SCAN;
            SC_COLON_SLASH: n_scan = slash ? SC_SKIP : SC_SCAN;
            default:        n_scan = SC_AT_NODE;
        endcase
    end

    assign store_ok = (r_count < LenC);
    assign s_eff    = r_found ? r_node : '0;

    // View bounds from the trackers
    always_comb begin
        n_lo = '0;
        n_hi = '0;
        case (i_view_sel)
            ave_pkg::VIEW_WHOLE: begin
                n_hi = r_count;
            end
            ave_pkg::VIEW_NODE_ID: begin
                if (s_eff < r_count) begin
                    n_lo = s_eff;
                    n_hi = r_s1_vld ? r_s1_pos : r_count;
                end
            end
            ave_pkg::VIEW_NO_HOST: begin
                n_lo = s_eff;
                n_hi = r_count;
            end
            default: begin
                if (r_s0_vld) begin
                    n_lo = r_s0_pos + OneC;
                    n_hi = r_count;
                end
            end
        endcase
    end

    assign o_sts.view_empty = (n_lo >= n_hi);
    assign o_sts.out_last   = r_empty || ((r_cur + OneC) == r_hi);

    // Per-address state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_scan   <= SC_START;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_node   <= '0;
            r_ovf    <= 1'b0;
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
        end else if (i_cmd.load) begin
            if (store_ok) begin
                r_scan  <= n_scan;
                r_count <= r_count + OneC;
                if (found_now) begin
                    r_found  <= 1'b1;
                    r_node   <= slash ? r_count + OneC : r_count;
                    r_s0_vld <= 1'b0;
                    r_s1_vld <= 1'b0;
                end else if (slash) begin
                    if (!r_s0_vld) begin
                        r_s0_vld <= 1'b1;
                        r_s0_pos <= r_count;
                    end
                    if (!r_s1_vld && r_count != s_eff) begin
                        r_s1_vld <= 1'b1;
                        r_s1_pos <= r_count;
                    end
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Emit position and bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_cur   <= n_lo;
            r_hi    <= n_hi;
            r_empty <= (n_lo >= n_hi);
        end else if (i_cmd.adv) begin
            r_cur <= r_cur + OneC;
        end
    end

    ave_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && store_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_addr_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Output payload
    assign o_out_byte    = r_empty ? 8'h00 : ram_rdata;
    assign o_out_last    = o_sts.out_last;
    assign o_field_empty = r_empty;
    assign o_too_long    = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LenC)
        else $error("byte count beyond store size");
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_node <= r_count)
        else $error("node start beyond stored bytes");
    a_slash_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_vld |-> (r_s0_pos < r_count && r_s0_pos >= s_eff))
        else $error("slash tracker outside node range");
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == LenC)
        else $error("overflow flagged before store was full");

endmodule

`default_nettype wire

// ===== src/ave_ctrl.sv =====
// Controller: input acceptance, view setup and the read/show sequence of the
// output bytes. Depends on ave_pkg.
`default_nettype none

module ave_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_last,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ave_pkg::t_ctl_cmd        o_cmd,
    input  wire ave_pkg::t_dp_status i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_SHOW
    } t_state;

    t_state r_state;
    logic   r_in_ready, r_out_valid;
    logic   in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && r_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // Commands decoded from state and handshakes
    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = in_xfer;
        o_cmd.setup = (r_state == ST_SETUP);
        o_cmd.rd    = (r_state == ST_READ);
        o_cmd.adv   = (r_state == ST_SHOW) && out_xfer && !i_sts.out_last;
        o_cmd.clr   = (r_state == ST_SHOW) && out_xfer && i_sts.out_last;
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer && i_in_last) begin
                        r_state    <= ST_SETUP;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_SETUP: begin
                    if (i_sts.view_empty) begin
                        r_state     <= ST_SHOW;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state     <= ST_SHOW;
                    r_out_valid <= 1'b1;
                end
                ST_SHOW: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (i_sts.out_last) begin
                            r_state    <= ST_IDLE;
                            r_in_ready <= 1'b1;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input and output open at once");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_last) |=> !r_in_ready)
        else $error("input still open after last byte");
    a_show_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ST_SHOW)
        else $error("output valid outside show state");

endmodule

`default_nettype wire

// ===== src/address_view_extractor_core.sv =====
// Top level of the address view extractor: view select register, controller
// and datapath. Depends on ave_pkg, ave_if, ave_ctrl and ave_datapath.
//
// Usage:
//   i_addr carries the octets of one address, one per transaction; last_byte
//   marks the final one. Up to MAX_LEN octets are stored; later octets are
//   dropped and too_long is set on every output of that address.
//   o_view carries the selected view, one octet per transaction, out_last on
//   the final one. An empty view gives a single transaction with out_byte 0,
//   out_last 1 and field_empty 1.
//   i_cfg_we/i_cfg_wdata write view_select; the value held during the view
//   setup that follows the last octet is used.
// Timing:
//   Octets go in one per cycle while idle. After the last one comes a setup
//   step; each output octet then needs a store read and then the transaction,
//   as the controller reads only after the previous transaction; an empty
//   view skips the read. Input stays closed until the final output is taken.
//   A stalled receiver simply holds the current output transaction.
// Reset:
//   Synchronous, active low; clears the scan, counts and view_select. The
//   byte store is not cleared and needs no clearing pass.
`default_nettype none

module address_view_extractor_core #(
    parameter int MAX_LEN = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ave_in_if.sink          i_addr,
    ave_out_if.source       o_view,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata
);

    ave_pkg::t_view     r_view_sel;
    ave_pkg::t_ctl_cmd  cmd;
    ave_pkg::t_dp_status sts;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_sel <= ave_pkg::VIEW_WHOLE;
        end else if (i_cfg_we) begin
            r_view_sel <= ave_pkg::t_view'(i_cfg_wdata);
        end
    end

    ave_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_addr.valid),
        .i_in_last   (i_addr.last_byte),
        .o_in_ready  (i_addr.ready),
        .o_out_valid (o_view.valid),
        .i_out_ready (o_view.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ave_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_addr_byte   (i_addr.addr_byte),
        .i_view_sel    (r_view_sel),
        .o_out_byte    (o_view.out_byte),
        .o_out_last    (o_view.out_last),
        .o_field_empty (o_view.field_empty),
        .o_too_long    (o_view.too_long)
    );

endmodule

`default_nettype wire
